// ----- design/dfs_pkg.sv -----
package dfs_pkg;

    localparam int MAX_SEPARATORS = 8;
    localparam int FIFO_DEPTH     = 4;
    localparam int MAX_RESULTS    = 3;

    localparam logic [7:0] SEP_DEFAULT = 8'h2C;

    localparam logic [2:0] REG_SEP_CHARS   = 3'd0;
    localparam logic [2:0] REG_SEP_COUNT   = 3'd1;
    localparam logic [2:0] REG_ESC_CHARS   = 3'd2;
    localparam logic [2:0] REG_ESC_COUNT   = 3'd3;
    localparam logic [2:0] REG_DROP_EMPTY  = 3'd4;
    localparam logic [2:0] REG_KEEP_QUOTES = 3'd5;

    typedef struct packed {
        logic [63:0] sep_chars;
        logic [3:0]  sep_count;
        logic [15:0] esc_chars;
        logic [1:0]  esc_count;
        logic        drop_empty;
        logic        keep_quotes;
    } cfg_t;

    // Results caused by one input item, entry 0 goes out first
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] res_byte;
        logic [MAX_RESULTS-1:0]      res_end;
        logic [1:0]                  res_num;
    } res_t;

endpackage

// ----- design/dfs_cfg.sv -----
module dfs_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    output dfs_pkg::cfg_t      cfg
);

    dfs_pkg::cfg_t cfg_reg;
    dfs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                dfs_pkg::REG_SEP_CHARS:   cfg_next.sep_chars   = cfg_data;
                dfs_pkg::REG_SEP_COUNT:   cfg_next.sep_count   = cfg_data[3:0];
                dfs_pkg::REG_ESC_CHARS:   cfg_next.esc_chars   = cfg_data[15:0];
                dfs_pkg::REG_ESC_COUNT:   cfg_next.esc_count   = cfg_data[1:0];
                dfs_pkg::REG_DROP_EMPTY:  cfg_next.drop_empty  = cfg_data[0];
                dfs_pkg::REG_KEEP_QUOTES: cfg_next.keep_quotes = cfg_data[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sep_chars   <= 64'({dfs_pkg::SEP_DEFAULT});
            cfg_reg.sep_count   <= 4'd1;
            cfg_reg.esc_chars   <= 16'd0;
            cfg_reg.esc_count   <= 2'd0;
            cfg_reg.drop_empty  <= 1'b0;
            cfg_reg.keep_quotes <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/dfs_front.sv -----
module dfs_front (
    input  logic               clk,
    input  logic               rst_n,
    input  dfs_pkg::cfg_t      cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tuser,
    input  logic               s_tlast,
    input  logic               fifo_full,
    output logic               push,
    output dfs_pkg::res_t      push_data
);

    localparam logic [1:0] MODE_PLAIN   = 2'd0;
    localparam logic [1:0] MODE_LITERAL = 2'd1;
    localparam logic [1:0] MODE_QUOTE   = 2'd2;

    logic in_quote_reg, close_pending_reg, literal_next_reg, field_has_chars_reg;
    logic string_started_reg;
    logic in_quote_next, close_pending_next, literal_next_next, field_has_chars_next;
    logic string_started_next;

    logic [7:0]    escl, escr, sep0, c;
    logic [3:0]    sep_used;
    logic [1:0]    mode;
    logic          sep_hit, done;
    logic          in_fire;
    dfs_pkg::res_t res;

    function automatic dfs_pkg::res_t add_res(input dfs_pkg::res_t r,
                                              input logic [7:0] b,
                                              input logic e);
        dfs_pkg::res_t v;
        v = r;
        if (v.res_num != 2'd3)
        begin
            v.res_byte[v.res_num] = b;
            v.res_end[v.res_num]  = e;
            v.res_num             = v.res_num + 2'd1;
        end
        return v;
    endfunction

    assign s_tready = !fifo_full;
    assign in_fire  = s_tvalid && s_tready;
    assign c        = s_tdata;

    always_comb
    begin
        escl = cfg.esc_chars[7:0];
        escr = (cfg.esc_count >= 2'd2) ? cfg.esc_chars[15:8] : escl;
        sep0 = (cfg.sep_count == 4'd0) ? dfs_pkg::SEP_DEFAULT : cfg.sep_chars[7:0];
        if (cfg.sep_count == 4'd0)
            sep_used = 4'd1;
        else if (cfg.sep_count > 4'(dfs_pkg::MAX_SEPARATORS))
            sep_used = 4'(dfs_pkg::MAX_SEPARATORS);
        else
            sep_used = cfg.sep_count;

        if (cfg.esc_count == 2'd0)
            mode = MODE_PLAIN;
        else if (escr == sep0)
            mode = MODE_LITERAL;
        else
            mode = MODE_QUOTE;

        sep_hit = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < sep_used)
            begin
                if (cfg.sep_count == 4'd0)
                begin
                    if (c == dfs_pkg::SEP_DEFAULT)
                        sep_hit = 1'b1;
                end
                else if (cfg.sep_chars[8*i +: 8] == c)
                begin
                    sep_hit = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        res                  = '0;
        done                 = 1'b0;
        in_quote_next        = in_quote_reg;
        close_pending_next   = close_pending_reg;
        literal_next_next    = literal_next_reg;
        field_has_chars_next = field_has_chars_reg;
        string_started_next  = string_started_reg;

        if (s_tuser)
        begin
            string_started_next = 1'b1;
            case (mode)
                MODE_PLAIN:
                begin
                    if (sep_hit)
                    begin
                        if (field_has_chars_next || !cfg.drop_empty)
                            res = add_res(res, 8'd0, 1'b1);
                        field_has_chars_next = 1'b0;
                    end
                    else
                    begin
                        res = add_res(res, c, 1'b0);
                        field_has_chars_next = 1'b1;
                    end
                end
                MODE_LITERAL:
                begin
                    if (literal_next_next)
                    begin
                        res = add_res(res, c, 1'b0);
                        field_has_chars_next = 1'b1;
                        literal_next_next    = 1'b0;
                    end
                    else if (c == escl)
                    begin
                        literal_next_next = 1'b1;
                    end
                    else if (sep_hit)
                    begin
                        if (field_has_chars_next || !cfg.drop_empty)
                            res = add_res(res, 8'd0, 1'b1);
                        field_has_chars_next = 1'b0;
                    end
                    else
                    begin
                        res = add_res(res, c, 1'b0);
                        field_has_chars_next = 1'b1;
                    end
                end
                default:
                begin
                    // resolve a right quote held from the previous byte
                    if (close_pending_next)
                    begin
                        close_pending_next = 1'b0;
                        if (c == escr)
                        begin
                            res = add_res(res, escr, 1'b0);
                            field_has_chars_next = 1'b1;
                            done = 1'b1;
                        end
                        else
                        begin
                            in_quote_next = 1'b0;
                            if (cfg.keep_quotes)
                            begin
                                res = add_res(res, escr, 1'b0);
                                field_has_chars_next = 1'b1;
                            end
                        end
                    end
                    if (!done)
                    begin
                        if (in_quote_next)
                        begin
                            if (c == escr)
                            begin
                                close_pending_next = 1'b1;
                            end
                            else
                            begin
                                res = add_res(res, c, 1'b0);
                                field_has_chars_next = 1'b1;
                            end
                        end
                        else if (c == escl)
                        begin
                            in_quote_next = 1'b1;
                            if (cfg.keep_quotes)
                            begin
                                res = add_res(res, c, 1'b0);
                                field_has_chars_next = 1'b1;
                            end
                        end
                        else if (sep_hit)
                        begin
                            if (field_has_chars_next || !cfg.drop_empty)
                                res = add_res(res, 8'd0, 1'b1);
                            field_has_chars_next = 1'b0;
                        end
                        else
                        begin
                            res = add_res(res, c, 1'b0);
                            field_has_chars_next = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (s_tlast)
        begin
            if (mode == MODE_QUOTE && close_pending_next && cfg.keep_quotes)
            begin
                res = add_res(res, escr, 1'b0);
                field_has_chars_next = 1'b1;
            end
            if (string_started_next)
            begin
                if (field_has_chars_next || !cfg.drop_empty)
                    res = add_res(res, 8'd0, 1'b1);
            end
            in_quote_next        = 1'b0;
            close_pending_next   = 1'b0;
            literal_next_next    = 1'b0;
            field_has_chars_next = 1'b0;
            string_started_next  = 1'b0;
        end
    end

    // items that produce nothing are consumed without a queue entry
    assign push      = in_fire && (res.res_num != 2'd0);
    assign push_data = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quote_reg        <= 1'b0;
            close_pending_reg   <= 1'b0;
            literal_next_reg    <= 1'b0;
            field_has_chars_reg <= 1'b0;
            string_started_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            in_quote_reg        <= in_quote_next;
            close_pending_reg   <= close_pending_next;
            literal_next_reg    <= literal_next_next;
            field_has_chars_reg <= field_has_chars_next;
            string_started_reg  <= string_started_next;
        end
    end

endmodule

// ----- design/dfs_fifo.sv -----
module dfs_fifo #(
    parameter int DEPTH = dfs_pkg::FIFO_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dfs_pkg::res_t      push_data,
    input  logic               pop,
    output dfs_pkg::res_t      pop_data,
    output logic               empty,
    output logic               full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    dfs_pkg::res_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on write");
`endif

endmodule

// ----- design/dfs_back.sv -----
module dfs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fifo_empty,
    input  dfs_pkg::res_t      fifo_data,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    logic          hold_valid_reg, hold_valid_next;
    dfs_pkg::res_t hold_reg, hold_next;
    logic [1:0]    idx_reg, idx_next;
    logic          last, xfer, load;

    assign last = (idx_reg == hold_reg.res_num - 2'd1);
    assign xfer = hold_valid_reg && m_tready;
    assign load = !hold_valid_reg || (xfer && last);
    assign pop  = load && !fifo_empty;

    assign m_tvalid = hold_valid_reg;
    assign m_tdata  = hold_reg.res_byte[idx_reg];
    assign m_tuser  = hold_reg.res_end[idx_reg];
    assign m_tlast  = last;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        idx_next        = idx_reg;
        if (load)
        begin
            hold_valid_next = !fifo_empty;
            hold_next       = fifo_data;
            idx_next        = 2'd0;
        end
        else if (xfer)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            idx_reg        <= idx_next;
        end
    end

`ifndef SYNTH
    a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (hold_reg.res_num != 2'd0))
        else $error("held bundle has no results");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (idx_reg < hold_reg.res_num))
        else $error("result index past bundle size");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && !last) |=> (hold_valid_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("result index did not step after transfer");
`endif

endmodule

// ----- design/delimited_field_splitter.sv -----
// An item's results are queued, then loaded into the hold register driving m_tdata. One
// item per cycle while the queue has room and items give at most one result each; an item
// with several results holds the output until all are sent; the queue absorbs those bursts.
// Items that give no result are taken every cycle while the queue has room, never queued.
// Reset (rst_n low, asynchronous): parse state cleared, queue and output emptied,
// registers back to separator ',', one separator, no escaping, keep empties, drop quotes.
module delimited_field_splitter #(
    parameter int FIFO_DEPTH = dfs_pkg::FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tuser,   // [0] field_end
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    dfs_pkg::cfg_t cfg;
    dfs_pkg::res_t push_data, pop_data;
    logic          push, pop, fifo_empty, fifo_full;

    dfs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    dfs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty),
        .full      (fifo_full)
    );

    dfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_data  (pop_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- dv/delimited_field_splitter_tb.sv -----
`timescale 1ns / 100ps

module delimited_field_splitter_tb;

    typedef enum logic [1:0] {MODE_PLAIN, MODE_LITERAL, MODE_QUOTE} split_mode_e;

    typedef struct packed {
        logic [7:0] chr;
        logic       term;
        logic       last;
    } field_beat_t;

    class field_scoreboard;
        logic [63:0] sep_chars;
        logic [3:0]  sep_count;
        logic [15:0] esc_chars;
        logic [1:0]  esc_count;
        logic        drop_empty;
        logic        keep_quotes;

        bit in_quote, close_pending, literal_next, has_chars, started;

        field_beat_t beats_due[$];
        field_beat_t burst[$];
        int          errors;

        function new();
            sep_chars   = {56'h0, dfs_pkg::SEP_DEFAULT};
            sep_count   = 4'd1;
            esc_chars   = 16'h0;
            esc_count   = 2'd0;
            drop_empty  = 1'b0;
            keep_quotes = 1'b0;
            in_quote = 0; close_pending = 0; literal_next = 0; has_chars = 0; started = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                dfs_pkg::REG_SEP_CHARS:   sep_chars   = val;
                dfs_pkg::REG_SEP_COUNT:   sep_count   = val[3:0];
                dfs_pkg::REG_ESC_CHARS:   esc_chars   = val[15:0];
                dfs_pkg::REG_ESC_COUNT:   esc_count   = val[1:0];
                dfs_pkg::REG_DROP_EMPTY:  drop_empty  = val[0];
                dfs_pkg::REG_KEEP_QUOTES: keep_quotes = val[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] sep_at(int i);
            if (sep_count == 0)
                return dfs_pkg::SEP_DEFAULT;
            return sep_chars[8*i +: 8];
        endfunction

        function bit is_sep(logic [7:0] c);
            int n;
            n = (sep_count == 0) ? 1 :
                (sep_count > dfs_pkg::MAX_SEPARATORS) ? dfs_pkg::MAX_SEPARATORS :
                int'(sep_count);
            for (int i = 0; i < n; i++)
                if (sep_at(i) == c)
                    return 1;
            return 0;
        endfunction

        function void emit_char(logic [7:0] c);
            burst.push_back('{c, 1'b0, 1'b0});
            has_chars = 1;
        endfunction

        function void emit_term();
            if (has_chars || !drop_empty)
                burst.push_back('{8'h00, 1'b1, 1'b0});
            has_chars = 0;
        endfunction

        // Work out the beats one accepted input transfer causes
        function void note_item(logic [7:0] c, logic valid, logic last);
            logic [7:0]  escl, escr;
            split_mode_e mode;
            bit          done;
            escl = esc_chars[7:0];
            escr = (esc_count >= 2) ? esc_chars[15:8] : escl;
            if (esc_count == 0)
                mode = MODE_PLAIN;
            else if (escr == sep_at(0))
                mode = MODE_LITERAL;
            else
                mode = MODE_QUOTE;
            burst.delete();

            if (valid)
            begin
                started = 1;
                case (mode)
                    MODE_PLAIN:
                    begin
                        if (is_sep(c))
                            emit_term();
                        else
                            emit_char(c);
                    end
                    MODE_LITERAL:
                    begin
                        if (literal_next)
                        begin
                            emit_char(c);
                            literal_next = 0;
                        end
                        else if (c == escl)
                            literal_next = 1;
                        else if (is_sep(c))
                            emit_term();
                        else
                            emit_char(c);
                    end
                    default:
                    begin
                        done = 0;
                        // resolve a right quote that waited for this byte
                        if (close_pending)
                        begin
                            close_pending = 0;
                            if (c == escr)
                            begin
                                emit_char(escr);
                                done = 1;
                            end
                            else
                            begin
                                in_quote = 0;
                                if (keep_quotes)
                                    emit_char(escr);
                            end
                        end
                        if (!done)
                        begin
                            if (in_quote)
                            begin
                                if (c == escr)
                                    close_pending = 1;
                                else
                                    emit_char(c);
                            end
                            else if (c == escl)
                            begin
                                in_quote = 1;
                                if (keep_quotes)
                                    emit_char(c);
                            end
                            else if (is_sep(c))
                                emit_term();
                            else
                                emit_char(c);
                        end
                    end
                endcase
            end

            if (last)
            begin
                if (mode == MODE_QUOTE && close_pending && keep_quotes)
                    emit_char(escr);
                if (started)
                    emit_term();
                in_quote = 0; close_pending = 0; literal_next = 0; has_chars = 0; started = 0;
            end

            if (burst.size() > 0)
                burst[burst.size()-1].last = 1'b1;
            foreach (burst[i])
                beats_due.push_back(burst[i]);
        endfunction

        function void check_result(field_beat_t got);
            field_beat_t exp_beat;
            if (beats_due.size() == 0)
            begin
                $display("%0t: unexpected beat chr=%h term=%b last=%b",
                         $time, got.chr, got.term, got.last);
                errors++;
                return;
            end
            exp_beat = beats_due.pop_front();
            if (got.chr !== exp_beat.chr)
            begin
                $display("%0t: out_byte expected %h actual %h", $time, exp_beat.chr, got.chr);
                errors++;
            end
            if (got.term !== exp_beat.term)
            begin
                $display("%0t: field_end expected %b actual %b", $time, exp_beat.term, got.term);
                errors++;
            end
            if (got.last !== exp_beat.last)
            begin
                $display("%0t: run_last expected %b actual %b", $time, exp_beat.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return beats_due.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [63:0] cfg_data  = 64'h0;

    field_scoreboard sb = new();
    dfs_pkg::cfg_t   cur_cfg;
    bit              idle_on = 1'b1;
    bit              calm    = 1'b0;
    int              items_sent = 0;

    delimited_field_splitter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Handshakes are sampled at the falling edge; the transfer lands on the next rising edge
    task automatic send_item(logic [7:0] b, logic v, logic e);
        bit hs;
        if (idle_on && !calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= v;
        s_tlast  <= e;
        do
        begin
            @(negedge clk);
            hs = s_tready;
            @(posedge clk);
        end
        while (!hs);
        sb.note_item(b, v, e);
        if (v || e)
            items_sent++;
        calm = items_sent >= 170;
    endtask

    task automatic program_regs(dfs_pkg::cfg_t c);
        logic [2:0]  idx [6];
        logic [63:0] val [6];
        logic [63:0] junk;
        bit          hs;
        junk   = {$urandom(), $urandom()};
        idx[0] = dfs_pkg::REG_SEP_CHARS;   val[0] = c.sep_chars;
        idx[1] = dfs_pkg::REG_SEP_COUNT;   val[1] = {junk[63:4], c.sep_count};
        idx[2] = dfs_pkg::REG_ESC_CHARS;   val[2] = {junk[63:16], c.esc_chars};
        idx[3] = dfs_pkg::REG_ESC_COUNT;   val[3] = {junk[63:2], c.esc_count};
        idx[4] = dfs_pkg::REG_DROP_EMPTY;  val[4] = {junk[63:1], c.drop_empty};
        idx[5] = dfs_pkg::REG_KEEP_QUOTES; val[5] = {junk[63:1], c.keep_quotes};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
            begin
                @(negedge clk);
                hs = cfg_ready;
                @(posedge clk);
            end
            while (!hs);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    // Hold the sender until every expected beat is out, then let the pipe empty
    task automatic settle();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (6) @(posedge clk);
    endtask

    function automatic dfs_pkg::cfg_t rand_cfg();
        dfs_pkg::cfg_t c;
        logic [7:0]    s0;
        int            pick;
        c.sep_chars = {$urandom(), $urandom()};
        pick = $urandom_range(0, 9);
        if (pick == 0)
            c.sep_count = 4'd0;
        else if (pick == 1)
            c.sep_count = 4'($urandom_range(9, 15));
        else
            c.sep_count = 4'($urandom_range(1, 8));
        s0 = (c.sep_count == 0) ? dfs_pkg::SEP_DEFAULT : c.sep_chars[7:0];
        c.esc_count = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 4))
            0: c.esc_chars = 16'($urandom());
            1: c.esc_chars = {s0, 8'h5C};
            2: c.esc_chars = 16'h2222;
            3: c.esc_chars = 16'h5D5B;
            default: c.esc_chars = {8'($urandom()), s0};
        endcase
        c.drop_empty  = 1'($urandom_range(0, 1));
        c.keep_quotes = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // Bias toward separators and escape bytes so every mode gets exercised
    function automatic logic [7:0] pick_byte();
        int n, r, k;
        n = (cur_cfg.sep_count == 0) ? 1 :
            (cur_cfg.sep_count > dfs_pkg::MAX_SEPARATORS) ? dfs_pkg::MAX_SEPARATORS :
            int'(cur_cfg.sep_count);
        r = $urandom_range(0, 9);
        k = $urandom_range(0, n - 1);
        if (r <= 2)
            return (cur_cfg.sep_count == 0) ? dfs_pkg::SEP_DEFAULT :
                   cur_cfg.sep_chars[8*k +: 8];
        if (r == 3)
            return cur_cfg.esc_chars[7:0];
        if (r == 4)
            return cur_cfg.esc_chars[15:8];
        if (r <= 7)
            return 8'(8'h61 + r);
        return 8'($urandom());
    endfunction

    task automatic send_string(int len, bit finish);
        bit end_on_byte;
        end_on_byte = $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom()), 1'b0, 1'b0);
            send_item(pick_byte(), 1'b1, finish && end_on_byte && i == len - 1);
        end
        if (finish && (len == 0 || !end_on_byte))
            send_item(8'($urandom()), 1'b0, 1'b1);
    endtask

    initial
    begin
        dfs_pkg::cfg_t c;
        int            guard;
        cur_cfg = '{sep_chars: {56'h0, dfs_pkg::SEP_DEFAULT}, sep_count: 4'd1,
                    esc_chars: 16'h0, esc_count: 2'd0, drop_empty: 1'b0, keep_quotes: 1'b0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain split with reset settings: ignored item, empty string, extreme bytes
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h2C, 1'b1, 1'b0);
        send_item(8'h2C, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        settle();

        // literal mode on the default separator, drop empties, pending literal at the end
        c = '{sep_chars: 64'hFFFF_FFFF_FFFF_FFFF, sep_count: 4'd0, esc_chars: 16'h2C5C,
              esc_count: 2'd2, drop_empty: 1'b1, keep_quotes: 1'b0};
        program_regs(c);
        send_item(8'h5C, 1'b1, 1'b0);
        send_item(8'h2C, 1'b1, 1'b0);
        send_item(8'h78, 1'b1, 1'b0);
        send_item(8'h2C, 1'b1, 1'b0);
        send_item(8'h2C, 1'b1, 1'b0);
        send_item(8'h79, 1'b1, 1'b0);
        send_item(8'h5C, 1'b1, 1'b1);
        settle();

        // quote mode, saturated separator count, doubled quote, three beats from one item
        c = '{sep_chars: 64'h2F2D_FF00_097C_3A3B, sep_count: 4'd15, esc_chars: 16'h2222,
              esc_count: 2'd3, drop_empty: 1'b0, keep_quotes: 1'b1};
        program_regs(c);
        send_item(8'h22, 1'b1, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h3A, 1'b1, 1'b0);
        send_item(8'h22, 1'b1, 1'b0);
        send_item(8'h22, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h22, 1'b1, 1'b0);
        send_item(8'h2F, 1'b1, 1'b1);
        send_item(8'h22, 1'b1, 1'b0);
        send_item(8'h22, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // open quote left hanging while the mode changes under it
        send_item(8'h22, 1'b1, 1'b0);
        send_item(8'h7A, 1'b1, 1'b0);
        settle();
        c.esc_count   = 2'd0;
        c.keep_quotes = 1'b0;
        program_regs(c);
        send_item(8'h71, 1'b1, 1'b1);

        while (items_sent < 200)
        begin
            settle();
            program_regs(rand_cfg());
            idle_on = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(3, 8)) send_string($urandom_range(0, 7), 1'b1);
            if ($urandom_range(0, 2) == 0)
                send_string($urandom_range(1, 4), 1'b0);
        end
        send_string(0, 1'b1);
        s_tvalid <= 1'b0;

        guard = 0;
        while (sb.pending() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected beats never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("[delimited_field_splitter] OK");
        else
            $display("[delimited_field_splitter] ERROR");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && !calm && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (m_tvalid === 1'b1 && m_tready)
                sb.check_result('{m_tdata, m_tuser, m_tlast});
        end
    end

    initial
    begin
        #2_000_000;
        $display("[delimited_field_splitter] ERROR");
        $finish;
    end

endmodule
